// ===== rtl/height_actuator_motion_controller_assert.svh =====
// Assertion macros for the height actuator motion controller.
// Expects signals named clk and rst_n in the including module.
`ifndef HEIGHT_ACTUATOR_MOTION_CONTROLLER_ASSERT_SVH
`define HEIGHT_ACTUATOR_MOTION_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HAMC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HAMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hamc_pkg.sv =====
// Types and constants shared by the height actuator motion controller.
// No dependencies; compile first after the assertion header.
package hamc_pkg;

    localparam int HEIGHT_W = 9;
    localparam int AGE_W    = 16;
    localparam int SLOT_W   = 8;
    localparam int TOL_W    = 8;
    localparam int MS_W     = 16;
    localparam int TIMER_W  = 17;
    localparam int DIST_W   = 13;   // 511 cm * 10 fits in 13 bits
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [3:0] MM_PER_CM = 4'd10;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_STAB  = 3'd3,
        MODE_ERROR = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SENSOR  = 2'd1,
        CAUSE_TIMEOUT = 2'd2,
        CAUSE_NOCAL   = 2'd3
    } cause_t;

    typedef enum logic [2:0] {
        REG_TOL     = 3'd0,
        REG_MIN     = 3'd1,
        REG_MAX     = 3'd2,
        REG_CAL     = 3'd3,
        REG_TIMEOUT = 3'd4,
        REG_STAB    = 3'd5,
        REG_STALE   = 3'd6
    } reg_idx_t;

    localparam logic [TOL_W-1:0]    TOL_RESET     = 8'd10;
    localparam logic [HEIGHT_W-1:0] MIN_RESET     = 9'd60;
    localparam logic [HEIGHT_W-1:0] MAX_RESET     = 9'd130;
    localparam logic [MS_W-1:0]     TIMEOUT_RESET = 16'd30000;
    localparam logic [MS_W-1:0]     STAB_RESET    = 16'd500;
    localparam logic [MS_W-1:0]     STALE_RESET   = 16'd500;

    typedef struct packed {
        logic [TOL_W-1:0]    tol_band_mm;
        logic [HEIGHT_W-1:0] min_height_cm;
        logic [HEIGHT_W-1:0] max_height_cm;
        logic                calibrated;
        logic [MS_W-1:0]     movement_timeout_ms;
        logic [MS_W-1:0]     stabilize_ms;
        logic [MS_W-1:0]     stale_limit_ms;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [HEIGHT_W-1:0] current_height_cm;
        logic                sensor_valid;
        logic [AGE_W-1:0]    reading_age_ms;
        logic [HEIGHT_W-1:0] request_cm;
        logic                from_preset;
        logic [SLOT_W-1:0]   slot_id;
    } item_t;

    typedef struct packed {
        mode_t               mode;
        logic [HEIGHT_W-1:0] goal_height;
        logic                goal_active;
        logic                goal_preset;
        logic [SLOT_W-1:0]   goal_slot;
        logic [TIMER_W-1:0]  move_elapsed;
        logic [TIMER_W-1:0]  settle_elapsed;
        cause_t              fault_cause;
    } state_t;

    typedef struct packed {
        mode_t             motion_state;
        logic              motor_up;
        logic              motor_down;
        logic              accepted;
        logic              target_active;
        cause_t            error_cause;
        logic              target_is_preset;
        logic [SLOT_W-1:0] target_slot;
    } result_t;

    localparam state_t STATE_RESET = '{
        mode:           MODE_IDLE,
        goal_height:    '0,
        goal_active:    1'b0,
        goal_preset:    1'b0,
        goal_slot:      '0,
        move_elapsed:   '0,
        settle_elapsed: '0,
        fault_cause:    CAUSE_NONE
    };

endpackage

// ===== rtl/hamc_if.sv =====
// Valid/ready channel interfaces for command items and status items.
// Depends on hamc_pkg for field widths.
interface hamc_cmd_if;
    import hamc_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [HEIGHT_W-1:0] current_height_cm;
    logic                sensor_valid;
    logic [AGE_W-1:0]    reading_age_ms;
    logic [HEIGHT_W-1:0] request_cm;
    logic                from_preset;
    logic [SLOT_W-1:0]   slot_id;

    modport source (
        output valid, kind, current_height_cm, sensor_valid, reading_age_ms,
               request_cm, from_preset, slot_id,
        input  ready
    );
    modport sink (
        input  valid, kind, current_height_cm, sensor_valid, reading_age_ms,
               request_cm, from_preset, slot_id,
        output ready
    );
endinterface

interface hamc_status_if;
    import hamc_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        motion_state;
    logic              motor_up;
    logic              motor_down;
    logic              accepted;
    logic              target_active;
    logic [1:0]        error_cause;
    logic              target_is_preset;
    logic [SLOT_W-1:0] target_slot;

    modport source (
        output valid, motion_state, motor_up, motor_down, accepted,
               target_active, error_cause, target_is_preset, target_slot,
        input  ready
    );
    modport sink (
        input  valid, motion_state, motor_up, motor_down, accepted,
               target_active, error_cause, target_is_preset, target_slot,
        output ready
    );
endinterface

// ===== rtl/hamc_cfg.sv =====
// APB-style configuration register file for the motion controller.
// Depends on hamc_pkg.
module hamc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hamc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hamc_pkg::DATA_W-1:0]   pwdata,
    output logic [hamc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output hamc_pkg::cfg_t                cfg
);
    import hamc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol_band_mm         <= TOL_RESET;
            cfg_reg.min_height_cm       <= MIN_RESET;
            cfg_reg.max_height_cm       <= MAX_RESET;
            cfg_reg.calibrated          <= 1'b0;
            cfg_reg.movement_timeout_ms <= TIMEOUT_RESET;
            cfg_reg.stabilize_ms        <= STAB_RESET;
            cfg_reg.stale_limit_ms      <= STALE_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TOL:     cfg_reg.tol_band_mm         <= pwdata[TOL_W-1:0];
                REG_MIN:     cfg_reg.min_height_cm       <= pwdata[HEIGHT_W-1:0];
                REG_MAX:     cfg_reg.max_height_cm       <= pwdata[HEIGHT_W-1:0];
                REG_CAL:     cfg_reg.calibrated          <= pwdata[0];
                REG_TIMEOUT: cfg_reg.movement_timeout_ms <= pwdata[MS_W-1:0];
                REG_STAB:    cfg_reg.stabilize_ms        <= pwdata[MS_W-1:0];
                REG_STALE:   cfg_reg.stale_limit_ms      <= pwdata[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TOL:     prdata = DATA_W'(cfg_reg.tol_band_mm);
            REG_MIN:     prdata = DATA_W'(cfg_reg.min_height_cm);
            REG_MAX:     prdata = DATA_W'(cfg_reg.max_height_cm);
            REG_CAL:     prdata = DATA_W'(cfg_reg.calibrated);
            REG_TIMEOUT: prdata = DATA_W'(cfg_reg.movement_timeout_ms);
            REG_STAB:    prdata = DATA_W'(cfg_reg.stabilize_ms);
            REG_STALE:   prdata = DATA_W'(cfg_reg.stale_limit_ms);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/hamc_step.sv =====
// Next-state and result logic for one command item.
// Depends on hamc_pkg.
module hamc_step (
    input  hamc_pkg::cfg_t    cfg,
    input  hamc_pkg::state_t  state,
    input  hamc_pkg::item_t   item,
    output hamc_pkg::state_t  state_next,
    output hamc_pkg::result_t result
);
    import hamc_pkg::*;

    logic [HEIGHT_W-1:0] ref_h;
    logic [HEIGHT_W-1:0] diff;
    logic [DIST_W-1:0]   dist_mm;
    logic                near;
    logic                above;
    mode_t               dir;
    logic                moving;
    logic                sensor_ok;
    logic                within_goal;
    logic                out_of_range;
    logic [TIMER_W-1:0]  move_inc;
    logic [TIMER_W-1:0]  settle_inc;
    logic                acc;

    // Set-target items measure against the requested height, all others
    // against the recorded goal.
    assign ref_h   = (item.kind == KIND_SET) ? item.request_cm : state.goal_height;
    assign above   = ref_h > item.current_height_cm;
    assign diff    = above ? (ref_h - item.current_height_cm)
                           : (item.current_height_cm - ref_h);
    assign dist_mm = DIST_W'(diff) * DIST_W'(MM_PER_CM);
    assign near    = dist_mm <= DIST_W'(cfg.tol_band_mm);
    assign dir     = above ? MODE_UP : MODE_DOWN;

    assign moving      = (state.mode == MODE_UP) || (state.mode == MODE_DOWN);
    assign sensor_ok   = item.sensor_valid || (item.reading_age_ms < cfg.stale_limit_ms);
    assign within_goal = state.goal_active && near;
    assign out_of_range = (item.request_cm < cfg.min_height_cm) ||
                          (item.request_cm > cfg.max_height_cm);

    assign move_inc   = (state.move_elapsed == TIMER_MAX) ? state.move_elapsed
                                                          : state.move_elapsed + 1'b1;
    assign settle_inc = (state.settle_elapsed == TIMER_MAX) ? state.settle_elapsed
                                                            : state.settle_elapsed + 1'b1;

    always_comb
    begin
        state_next = state;
        acc        = 1'b0;
        case (item.kind)
            KIND_TICK:
            begin
                state_next.move_elapsed   = move_inc;
                state_next.settle_elapsed = settle_inc;
                if (moving && !sensor_ok)
                begin
                    state_next.mode        = MODE_ERROR;
                    state_next.fault_cause = CAUSE_SENSOR;
                end
                else if (moving && (move_inc > TIMER_W'(cfg.movement_timeout_ms)))
                begin
                    state_next.mode        = MODE_ERROR;
                    state_next.fault_cause = CAUSE_TIMEOUT;
                end
                else
                begin
                    case (state.mode)
                        MODE_IDLE:
                        begin
                            if (state.goal_active && !near)
                            begin
                                state_next.move_elapsed = '0;
                                state_next.mode         = dir;
                            end
                        end
                        MODE_UP, MODE_DOWN:
                        begin
                            if (within_goal)
                            begin
                                state_next.mode           = MODE_STAB;
                                state_next.settle_elapsed = '0;
                            end
                            else if (state.goal_active)
                            begin
                                state_next.mode = dir;
                            end
                        end
                        MODE_STAB:
                        begin
                            if (!within_goal)
                            begin
                                // movement timer keeps running on resume
                                if (state.goal_active)
                                begin
                                    state_next.mode = dir;
                                end
                            end
                            else if (settle_inc >= TIMER_W'(cfg.stabilize_ms))
                            begin
                                state_next.goal_active = 1'b0;
                                state_next.mode        = MODE_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            KIND_SET:
            begin
                if (out_of_range)
                begin
                end
                else if (!cfg.calibrated)
                begin
                    state_next.fault_cause = CAUSE_NOCAL;
                end
                else if (state.mode != MODE_ERROR)
                begin
                    acc                    = 1'b1;
                    state_next.goal_height = item.request_cm;
                    state_next.goal_preset = item.from_preset;
                    state_next.goal_slot   = item.from_preset ? item.slot_id : '0;
                    if (near)
                    begin
                        state_next.goal_active = 1'b0;
                    end
                    else
                    begin
                        state_next.goal_active  = 1'b1;
                        state_next.move_elapsed = '0;
                        state_next.mode         = dir;
                    end
                end
            end
            KIND_STOP:
            begin
                state_next.goal_active = 1'b0;
                state_next.mode        = MODE_IDLE;
            end
            KIND_CLEAR:
            begin
                if (state.mode == MODE_ERROR)
                begin
                    state_next.goal_active = 1'b0;
                    state_next.fault_cause = CAUSE_NONE;
                    state_next.mode        = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.motion_state     = state_next.mode;
        result.motor_up         = state_next.mode == MODE_UP;
        result.motor_down       = state_next.mode == MODE_DOWN;
        result.accepted         = acc;
        result.target_active    = state_next.goal_active;
        result.error_cause      = state_next.fault_cause;
        result.target_is_preset = state_next.goal_preset;
        result.target_slot      = state_next.goal_slot;
    end

endmodule

// ===== rtl/height_actuator_motion_controller.sv =====
// Top level of the height actuator motion controller: channel registers,
// controller state and configuration. Depends on hamc_pkg, hamc_if,
// hamc_cfg, hamc_step and the assertion header.

// The controller takes one command item per clock on cmd (a 1 ms tick with
// the sensor reading, a set-target request, an emergency stop or a clear
// error) while status is drained, and returns exactly one status item per
// command on status, in order. A command waits in the input register and
// moves to the status register when that register is free or being
// drained, and its status item is then offered on status. The
// combinational next-state logic in hamc_step sets the rate of one item
// per clock. With the status sink stalled, the input register takes at
// most one more item and then cmd.ready stays low until the waiting status
// item is taken. Motor outputs are decoded from the state, so up and down
// are never on together.
// Millisecond timers advance only on tick items and saturate at 131071.
// Configuration registers sit on the APB port at byte address 4*i and are
// meant to be written while no command is in flight; there is no start-up
// clearing pass.
module height_actuator_motion_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    hamc_cmd_if.sink                      cmd,
    hamc_status_if.source                 status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hamc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hamc_pkg::DATA_W-1:0]   pwdata,
    output logic [hamc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import hamc_pkg::*;

    `include "height_actuator_motion_controller_assert.svh"

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_vld_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_vld_reg;
    logic    advance;

    hamc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hamc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // An item moves from the input register to the status register when
    // the status register is empty or being drained this cycle.
    assign advance   = in_vld_reg && (!out_vld_reg || status.ready);
    assign cmd.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            item_reg.kind              <= kind_t'(cmd.kind);
            item_reg.current_height_cm <= cmd.current_height_cm;
            item_reg.sensor_valid      <= cmd.sensor_valid;
            item_reg.reading_age_ms    <= cmd.reading_age_ms;
            item_reg.request_cm        <= cmd.request_cm;
            item_reg.from_preset       <= cmd.from_preset;
            item_reg.slot_id           <= cmd.slot_id;
        end
    end

    // controller state commits together with the status item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign status.valid            = out_vld_reg;
    assign status.motion_state     = result_reg.motion_state;
    assign status.motor_up         = result_reg.motor_up;
    assign status.motor_down       = result_reg.motor_down;
    assign status.accepted         = result_reg.accepted;
    assign status.target_active    = result_reg.target_active;
    assign status.error_cause      = result_reg.error_cause;
    assign status.target_is_preset = result_reg.target_is_preset;
    assign status.target_slot      = result_reg.target_slot;

    // Error is only ever entered with a cause recorded, and clear drops both.
    `HAMC_ASSERT_IMPLY(a_error_has_cause, state_reg.mode == MODE_ERROR,
        state_reg.fault_cause != CAUSE_NONE, "error state without a cause")
    // Manual targets record slot zero.
    `HAMC_ASSERT_IMPLY(a_manual_slot_zero, !state_reg.goal_preset,
        state_reg.goal_slot == '0, "manual target with nonzero slot")
    // A target is never accepted while in error.
    `HAMC_ASSERT_IMPLY(a_accept_not_error, out_vld_reg && result_reg.accepted,
        result_reg.motion_state != MODE_ERROR, "target accepted in error")
    // Every item that leaves the input register lands in the status register.
    `HAMC_ASSERT_NEXT(a_advance_fills, advance, out_vld_reg, "advanced item lost")

endmodule
